// ===== rtl/bwf_pkg.sv =====
// Package for the binomial window filter: shared widths, config indexes and
// the per-beat status struct. No dependencies.
`timescale 1ns / 1ps
package bwf_pkg;

  localparam int unsigned PIX_W = 8;
  localparam int unsigned RGB_W = 3 * PIX_W;
  localparam int unsigned CFG_W = 12;
  localparam int unsigned WIDTH_W = 11;
  localparam int unsigned HEIGHT_W = 12;
  localparam int unsigned TAPS_W = 4;

  localparam logic [WIDTH_W-1:0] WIDTH_RST = 11'd1024;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 12'd1024;
  localparam logic [TAPS_W-1:0] TAPS_RST = 4'd3;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_TAPS   = 2'd2
  } bwf_cfg_e;

  typedef struct packed {
    logic keep;
    logic frame_end;
  } bwf_meta_t;

endpackage

// ===== rtl/bwf_pix_if.sv =====
// Stream interfaces of the binomial window filter: pixel input and result
// output, valid/ready handshake. Depends on bwf_pkg.
`timescale 1ns / 1ps
interface bwf_pix_if;
  logic valid;
  logic ready;
  logic [bwf_pkg::PIX_W-1:0] pixel_blue;
  logic [bwf_pkg::PIX_W-1:0] pixel_green;
  logic [bwf_pkg::PIX_W-1:0] pixel_red;
  modport source (output valid, pixel_blue, pixel_green, pixel_red, input ready);
  modport sink (input valid, pixel_blue, pixel_green, pixel_red, output ready);
endinterface

interface bwf_res_if;
  logic valid;
  logic ready;
  logic [bwf_pkg::PIX_W-1:0] out_blue;
  logic [bwf_pkg::PIX_W-1:0] out_green;
  logic [bwf_pkg::PIX_W-1:0] out_red;
  logic out_valid;
  logic frame_end;
  modport source (output valid, out_blue, out_green, out_red, out_valid, frame_end,
                  input ready);
  modport sink (input valid, out_blue, out_green, out_red, out_valid, frame_end,
                output ready);
endinterface

// ===== rtl/bwf_conv.sv =====
// Weighted-sum pipeline: column sums, row sum, shift and output register.
// Depends on bwf_pkg.
`timescale 1ns / 1ps
module bwf_conv #(
  parameter int MAX_TAPS = 9
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic in_v_i,
  input  bwf_pkg::bwf_meta_t meta_i,
  input  logic [bwf_pkg::RGB_W-1:0] win_i [MAX_TAPS][MAX_TAPS],
  input  logic [MAX_TAPS-1:0] wt_i [MAX_TAPS],
  input  logic [4:0] sh_i,
  output logic out_v_o,
  output bwf_pkg::bwf_meta_t meta_o,
  output logic [bwf_pkg::PIX_W-1:0] out_b_o,
  output logic [bwf_pkg::PIX_W-1:0] out_g_o,
  output logic [bwf_pkg::PIX_W-1:0] out_r_o
);
  localparam int VW = MAX_TAPS + 7;
  localparam int HW = 2 * MAX_TAPS + 6;

  logic [VW-1:0] vs_d [MAX_TAPS][3];
  logic [VW-1:0] vs_q [MAX_TAPS][3];
  logic [HW-1:0] hs_d [3];
  logic [HW-1:0] hs_q [3];
  logic [bwf_pkg::PIX_W-1:0] px_d [3];
  logic [bwf_pkg::PIX_W-1:0] px_q [3];
  logic v_v_q, h_v_q, o_v_q;
  bwf_pkg::bwf_meta_t v_m_q, h_m_q, o_m_q;

  // skip taps outside the active window
  always_comb begin
    for (int c = 0; c < MAX_TAPS; c++) begin
      for (int ch = 0; ch < 3; ch++) begin
        vs_d[c][ch] = '0;
        for (int i = 0; i < MAX_TAPS; i++) begin
          if (wt_i[i] != '0) begin
            vs_d[c][ch] = vs_d[c][ch] + VW'(VW'(win_i[i][c][ch*8 +: 8]) * VW'(wt_i[i]));
          end
        end
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      hs_d[ch] = '0;
      for (int c = 0; c < MAX_TAPS; c++) begin
        if (wt_i[c] != '0) begin
          hs_d[ch] = hs_d[ch] + HW'(HW'(vs_q[c][ch]) * HW'(wt_i[c]));
        end
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      px_d[ch] = h_m_q.keep ? 8'(hs_q[ch] >> sh_i) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_v_q <= 1'b0;
      h_v_q <= 1'b0;
      o_v_q <= 1'b0;
      v_m_q <= '0;
      h_m_q <= '0;
      o_m_q <= '0;
    end else if (en_i) begin
      v_v_q <= in_v_i;
      h_v_q <= v_v_q;
      o_v_q <= h_v_q;
      v_m_q <= meta_i;
      h_m_q <= v_m_q;
      o_m_q <= h_m_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vs_q <= vs_d;
      hs_q <= hs_d;
      px_q <= px_d;
    end
  end

  assign out_v_o = o_v_q;
  assign meta_o = o_m_q;
  assign out_b_o = px_q[0];
  assign out_g_o = px_q[1];
  assign out_r_o = px_q[2];

endmodule

// ===== rtl/binomial_window_filter_rgb.sv =====
// Top level of the binomial window filter: config registers, raster
// counters, line memory and window. Depends on bwf_pkg, bwf_pix_if, bwf_conv.
// One pixel per cycle unless the result output stalls. The line memory is read
// at accept and written back from the input register, one column word per
// pixel; same-column back-to-back accesses are forwarded.
// Reset clears counters, window and pipeline; the line memory is not cleared.
`timescale 1ns / 1ps
module binomial_window_filter_rgb #(
  parameter int MAX_TAPS = 9,
  parameter int MAX_WIDTH = 1024
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [bwf_pkg::CFG_W-1:0] cfg_data_i,
  bwf_pix_if.sink pix_i,
  bwf_res_if.source res_o
);
  localparam int LINES = (MAX_TAPS > 1) ? MAX_TAPS - 1 : 1;
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int RW = bwf_pkg::RGB_W;

  logic [bwf_pkg::WIDTH_W-1:0] width_q;
  logic [bwf_pkg::HEIGHT_W-1:0] height_q;
  logic [bwf_pkg::TAPS_W-1:0] taps_q;
  logic [12:0] w_eff;
  logic [11:0] h_eff;
  logic [3:0] t_eff, d2;
  logic [AW-1:0] col_q;
  logic [11:0] row_q;
  logic en, acc, last_col, last_row, keep, wr_en;

  logic s1_v_q, fwd_q;
  logic [AW-1:0] s1_addr_q;
  logic [RW-1:0] s1_pix_q;
  bwf_pkg::bwf_meta_t s1_m_q, w_m_q, o_meta;
  logic w_v_q, o_v;

  logic [LINES*RW-1:0] mem [MAX_WIDTH];
  logic [LINES*RW-1:0] rd_q, wd_q, old_col, wdata;
  logic [RW-1:0] win_q [MAX_TAPS][MAX_TAPS];
  logic [RW-1:0] column [MAX_TAPS];
  logic [MAX_TAPS-1:0] wt_d [MAX_TAPS];
  logic [MAX_TAPS-1:0] wt_q [MAX_TAPS];

  always_comb begin
    w_eff = {2'b00, width_q};
    if (w_eff == '0) w_eff = 13'd1;
    else if (w_eff > 13'(MAX_WIDTH)) w_eff = 13'(MAX_WIDTH);
    h_eff = height_q;
    if (h_eff == '0) h_eff = 12'd1;
    t_eff = taps_q;
    if (t_eff > 4'(MAX_TAPS)) t_eff = 4'(MAX_TAPS);
    if (t_eff == '0) t_eff = 4'd1;
    if (!t_eff[0]) t_eff = t_eff - 4'd1;
    d2 = t_eff - 4'd1;
  end

  assign last_col = (13'(col_q) + 13'd1) >= w_eff;
  assign last_row = (13'(row_q) + 13'd1) >= 13'(h_eff);
  assign keep = (13'(col_q) < w_eff) && (row_q < h_eff) &&
                (13'(col_q) >= 13'(d2)) && (row_q >= 12'(d2));

  assign en = !o_v || res_o.ready;
  assign acc = pix_i.valid && en;
  assign wr_en = en && s1_v_q;
  assign pix_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= bwf_pkg::WIDTH_RST;
      height_q <= bwf_pkg::HEIGHT_RST;
      taps_q <= bwf_pkg::TAPS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bwf_pkg::CFG_WIDTH: width_q <= cfg_data_i[bwf_pkg::WIDTH_W-1:0];
        bwf_pkg::CFG_HEIGHT: height_q <= cfg_data_i[bwf_pkg::HEIGHT_W-1:0];
        bwf_pkg::CFG_TAPS: taps_q <= cfg_data_i[bwf_pkg::TAPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (acc) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + 12'd1;
      end else begin
        col_q <= col_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      w_v_q <= 1'b0;
      fwd_q <= 1'b0;
      s1_m_q <= '0;
      w_m_q <= '0;
    end else if (en) begin
      s1_v_q <= pix_i.valid;
      w_v_q <= s1_v_q;
      w_m_q <= s1_m_q;
      if (acc) begin
        fwd_q <= wr_en && (s1_addr_q == col_q);
        s1_m_q.keep <= keep;
        s1_m_q.frame_end <= last_col && last_row;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_addr_q <= col_q;
      s1_pix_q <= {pix_i.pixel_red, pix_i.pixel_green, pix_i.pixel_blue};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[s1_addr_q] <= wdata;
      wd_q <= wdata;
    end
    if (acc) begin
      rd_q <= mem[col_q];
    end
  end

  always_comb begin
    old_col = fwd_q ? wd_q : rd_q;
    for (int k = 0; k < MAX_TAPS - 1; k++) begin
      column[k] = old_col[k*RW +: RW];
    end
    column[MAX_TAPS-1] = s1_pix_q;
    wdata = old_col;
    for (int k = 0; k < LINES - 1; k++) begin
      wdata[k*RW +: RW] = old_col[(k+1)*RW +: RW];
    end
    wdata[(LINES-1)*RW +: RW] = s1_pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_TAPS; k++) begin
        for (int j = 0; j < MAX_TAPS; j++) begin
          win_q[k][j] <= '0;
        end
      end
    end else if (wr_en) begin
      for (int k = 0; k < MAX_TAPS; k++) begin
        for (int j = 0; j < MAX_TAPS - 1; j++) begin
          win_q[k][j] <= win_q[k][j+1];
        end
        win_q[k][MAX_TAPS-1] <= column[k];
      end
    end
  end

  // Pascal row t-1, right-aligned in the window
  always_comb begin
    for (int i = 0; i < MAX_TAPS; i++) begin
      wt_d[i] = '0;
    end
    wt_d[MAX_TAPS-1] = MAX_TAPS'(1);
    for (int n = 1; n < MAX_TAPS; n++) begin
      if (4'(n) < t_eff) begin
        for (int j = 0; j < MAX_TAPS - 1; j++) begin
          wt_d[j] = wt_d[j] + wt_d[j+1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wt_q <= wt_d;
  end

  bwf_conv #(
    .MAX_TAPS(MAX_TAPS)
  ) u_conv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .in_v_i (w_v_q),
    .meta_i (w_m_q),
    .win_i  (win_q),
    .wt_i   (wt_q),
    .sh_i   ({d2, 1'b0}),
    .out_v_o(o_v),
    .meta_o (o_meta),
    .out_b_o(res_o.out_blue),
    .out_g_o(res_o.out_green),
    .out_r_o(res_o.out_red)
  );

  assign res_o.valid = o_v;
  assign res_o.out_valid = o_meta.keep;
  assign res_o.frame_end = o_meta.frame_end;

endmodule
